>>> rtl/core/hnpf_pkg.sv
// ----------------------------------------------------------------------------
// hnpf_pkg
// Shared types and constants for the half neighbor pair filter.
// ----------------------------------------------------------------------------
package hnpf_pkg;

   localparam int MAX_NEIGH       = 2048;
   localparam int COUNT_W         = 12;
   localparam int COUNT_FIELD_MAX = (1 << COUNT_W) - 1;

   // Saturation point of the per-owner count, clipped to what the field shows
   localparam logic [COUNT_W-1:0] COUNT_LIMIT =
      COUNT_W'((MAX_NEIGH > COUNT_FIELD_MAX) ? COUNT_FIELD_MAX : MAX_NEIGH);

   localparam int IDX_W   = 29;
   localparam int WORD_W  = 32;
   localparam int COORD_W = 32;
   localparam int CSR_W   = 64;

   typedef enum logic [2:0] {
      CSR_NEWTON_MODE    = 3'd0,
      CSR_TRICLINIC_MODE = 3'd1,
      CSR_TRIM_MODE      = 3'd2,
      CSR_LOCAL_COUNT    = 3'd3,
      CSR_TIE_DELTA      = 3'd4,
      CSR_CUTOFF_SQ      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic        newton_mode;
      logic        triclinic_mode;
      logic        trim_mode;
      logic [29:0] local_count;
      logic [30:0] tie_delta;
      logic [63:0] cutoff_sq;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      newton_mode:    1'b1,
      triclinic_mode: 1'b0,
      trim_mode:      1'b0,
      local_count:    30'd0,
      tie_delta:      31'd655,
      cutoff_sq:      64'd0
   };

   typedef logic [COORD_W-1:0] mag_type;

endpackage

>>> rtl/core/hnpf_geom.sv
// ----------------------------------------------------------------------------
// hnpf_geom
// Half-list ordering decision and per-axis distance magnitudes for one pair.
// ----------------------------------------------------------------------------
module hnpf_geom (
   input  hnpf_pkg::cfg_type                          cfg,
   input  logic [hnpf_pkg::IDX_W-1:0]                 owner_index,
   input  logic [hnpf_pkg::IDX_W-1:0]                 neighbor_index,
   input  logic signed [hnpf_pkg::COORD_W-1:0]        owner_x,
   input  logic signed [hnpf_pkg::COORD_W-1:0]        owner_y,
   input  logic signed [hnpf_pkg::COORD_W-1:0]        owner_z,
   input  logic signed [hnpf_pkg::COORD_W-1:0]        neighbor_x,
   input  logic signed [hnpf_pkg::COORD_W-1:0]        neighbor_y,
   input  logic signed [hnpf_pkg::COORD_W-1:0]        neighbor_z,
   output logic                                       keep_order,
   output hnpf_pkg::mag_type                          mag_x,
   output hnpf_pkg::mag_type                          mag_y,
   output hnpf_pkg::mag_type                          mag_z
);

   logic signed [hnpf_pkg::COORD_W:0] dx;
   logic signed [hnpf_pkg::COORD_W:0] dy;
   logic signed [hnpf_pkg::COORD_W:0] dz;
   logic                              nbr_local;
   logic                              z_far;
   logic                              y_far;
   logic                              tri_keep;
   logic                              ortho_keep;

   // Differences need one extra bit; their magnitude still fits 32 bits
   assign dx = {neighbor_x[hnpf_pkg::COORD_W-1], neighbor_x}
             - {owner_x[hnpf_pkg::COORD_W-1], owner_x};
   assign dy = {neighbor_y[hnpf_pkg::COORD_W-1], neighbor_y}
             - {owner_y[hnpf_pkg::COORD_W-1], owner_y};
   assign dz = {neighbor_z[hnpf_pkg::COORD_W-1], neighbor_z}
             - {owner_z[hnpf_pkg::COORD_W-1], owner_z};

   assign mag_x = dx[hnpf_pkg::COORD_W] ? hnpf_pkg::COORD_W'(-dx) : dx[hnpf_pkg::COORD_W-1:0];
   assign mag_y = dy[hnpf_pkg::COORD_W] ? hnpf_pkg::COORD_W'(-dy) : dy[hnpf_pkg::COORD_W-1:0];
   assign mag_z = dz[hnpf_pkg::COORD_W] ? hnpf_pkg::COORD_W'(-dz) : dz[hnpf_pkg::COORD_W-1:0];

   assign nbr_local = {1'b0, neighbor_index} < cfg.local_count;

   assign z_far = mag_z > {1'b0, cfg.tie_delta};
   assign y_far = mag_y > {1'b0, cfg.tie_delta};

   always_comb begin
      if (z_far) begin
         tri_keep = neighbor_z >= owner_z;
      end else if (y_far) begin
         tri_keep = neighbor_y >= owner_y;
      end else begin
         tri_keep = neighbor_x >= owner_x;
      end

      // exact lexicographic order, z first
      if (neighbor_z != owner_z) begin
         ortho_keep = neighbor_z > owner_z;
      end else if (neighbor_y != owner_y) begin
         ortho_keep = neighbor_y > owner_y;
      end else begin
         ortho_keep = neighbor_x >= owner_x;
      end

      if (!cfg.newton_mode) begin
         keep_order = neighbor_index > owner_index;
      end else if (nbr_local) begin
         keep_order = owner_index <= neighbor_index;
      end else if (cfg.triclinic_mode) begin
         keep_order = tri_keep;
      end else begin
         keep_order = ortho_keep;
      end
   end

endmodule

>>> rtl/core/half_neighbor_pair_filter_core.sv
// ----------------------------------------------------------------------------
// half_neighbor_pair_filter_core
// Filters a full neighbor list stream down to a half list, with optional
// distance trim and a saturating per-owner kept count.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one candidate pair per transaction (owner index, neighbor
//   word, both coordinates, end-of-owner mark). rsp_* returns exactly one
//   result transaction per request, in order: keep decision, the neighbor
//   word unchanged, the running kept count and the overflow flag.
//   csr_* writes the mode and threshold registers; write only while idle.
// Throughput: one transaction per cycle, sustained while rsp_ready stays high.
// Path: input register, the squaring stage (three 32x32 multipliers),
//   then the sum, cutoff compare and count update into the result
//   register.
// Stall: each stage loads whenever it is empty or its successor moves, so
//   a held result does not block earlier stages until they fill up;
//   req_ready drops only when all three stages hold transactions and
//   rsp_ready is low.
// Reset: synchronous, active high; clears all stage valids, the per-owner
//   count and overflow, and loads register defaults (newton on, tolerance
//   655 = 0.01 in Q16.16, everything else zero).
// ----------------------------------------------------------------------------
module half_neighbor_pair_filter_core (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [hnpf_pkg::IDX_W-1:0]          req_owner_index,
   input  logic [hnpf_pkg::WORD_W-1:0]         req_neighbor_word,
   input  logic signed [hnpf_pkg::COORD_W-1:0] req_owner_x,
   input  logic signed [hnpf_pkg::COORD_W-1:0] req_owner_y,
   input  logic signed [hnpf_pkg::COORD_W-1:0] req_owner_z,
   input  logic signed [hnpf_pkg::COORD_W-1:0] req_neighbor_x,
   input  logic signed [hnpf_pkg::COORD_W-1:0] req_neighbor_y,
   input  logic signed [hnpf_pkg::COORD_W-1:0] req_neighbor_z,
   input  logic                                req_last_of_owner,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_keep,
   output logic [hnpf_pkg::WORD_W-1:0]         rsp_kept_word,
   output logic [hnpf_pkg::COUNT_W-1:0]        rsp_kept_count,
   output logic                                rsp_owner_done,
   output logic                                rsp_overflow,

   input  logic                                csr_write_enable,
   input  logic [2:0]                          csr_index,
   input  logic [hnpf_pkg::CSR_W-1:0]          csr_write_data
);

   // ---------------- configuration registers ----------------
   hnpf_pkg::cfg_type cfg_ff;
   hnpf_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            hnpf_pkg::CSR_NEWTON_MODE:    cfg_in.newton_mode    = csr_write_data[0];
            hnpf_pkg::CSR_TRICLINIC_MODE: cfg_in.triclinic_mode = csr_write_data[0];
            hnpf_pkg::CSR_TRIM_MODE:      cfg_in.trim_mode      = csr_write_data[0];
            hnpf_pkg::CSR_LOCAL_COUNT:    cfg_in.local_count    = csr_write_data[29:0];
            hnpf_pkg::CSR_TIE_DELTA:      cfg_in.tie_delta      = csr_write_data[30:0];
            hnpf_pkg::CSR_CUTOFF_SQ:      cfg_in.cutoff_sq      = csr_write_data;
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= hnpf_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- stage handshake ----------------
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic rsp_valid_ff;
   logic out_load;   // result register takes a transaction from stage 2
   logic s2_load;    // stage 2 takes a transaction from stage 1
   logic s1_load;    // input register takes a request
   logic out_free;
   logic s2_free;
   logic s1_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = s1_free;

   assign s1_load  = req_valid && s1_free;
   assign s2_load  = s1_valid_ff && s2_free;
   assign out_load = s2_valid_ff && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   // ---------------- stage 1: input register ----------------
   logic [hnpf_pkg::IDX_W-1:0]          s1_owner_index_ff;
   logic [hnpf_pkg::WORD_W-1:0]         s1_word_ff;
   logic signed [hnpf_pkg::COORD_W-1:0] s1_owner_x_ff;
   logic signed [hnpf_pkg::COORD_W-1:0] s1_owner_y_ff;
   logic signed [hnpf_pkg::COORD_W-1:0] s1_owner_z_ff;
   logic signed [hnpf_pkg::COORD_W-1:0] s1_nbr_x_ff;
   logic signed [hnpf_pkg::COORD_W-1:0] s1_nbr_y_ff;
   logic signed [hnpf_pkg::COORD_W-1:0] s1_nbr_z_ff;
   logic                                s1_last_ff;

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_owner_index_ff <= req_owner_index;
         s1_word_ff        <= req_neighbor_word;
         s1_owner_x_ff     <= req_owner_x;
         s1_owner_y_ff     <= req_owner_y;
         s1_owner_z_ff     <= req_owner_z;
         s1_nbr_x_ff       <= req_neighbor_x;
         s1_nbr_y_ff       <= req_neighbor_y;
         s1_nbr_z_ff       <= req_neighbor_z;
         s1_last_ff        <= req_last_of_owner;
      end
   end

   // ---------------- stage 2: ordering and squares ----------------
   logic              keep_order;
   hnpf_pkg::mag_type mag_x;
   hnpf_pkg::mag_type mag_y;
   hnpf_pkg::mag_type mag_z;

   hnpf_geom u_geom (
      .cfg            (cfg_ff),
      .owner_index    (s1_owner_index_ff),
      .neighbor_index (s1_word_ff[hnpf_pkg::IDX_W-1:0]),
      .owner_x        (s1_owner_x_ff),
      .owner_y        (s1_owner_y_ff),
      .owner_z        (s1_owner_z_ff),
      .neighbor_x     (s1_nbr_x_ff),
      .neighbor_y     (s1_nbr_y_ff),
      .neighbor_z     (s1_nbr_z_ff),
      .keep_order     (keep_order),
      .mag_x          (mag_x),
      .mag_y          (mag_y),
      .mag_z          (mag_z)
   );

   logic [2*hnpf_pkg::COORD_W-1:0] sq_x_in;
   logic [2*hnpf_pkg::COORD_W-1:0] sq_y_in;
   logic [2*hnpf_pkg::COORD_W-1:0] sq_z_in;
   logic [2*hnpf_pkg::COORD_W-1:0] s2_sq_x_ff;
   logic [2*hnpf_pkg::COORD_W-1:0] s2_sq_y_ff;
   logic [2*hnpf_pkg::COORD_W-1:0] s2_sq_z_ff;
   logic                           s2_keep_order_ff;
   logic [hnpf_pkg::WORD_W-1:0]    s2_word_ff;
   logic                           s2_last_ff;

   // 32x32 unsigned squares; |d| never exceeds 2^32-1
   assign sq_x_in = (2*hnpf_pkg::COORD_W)'(mag_x) * (2*hnpf_pkg::COORD_W)'(mag_x);
   assign sq_y_in = (2*hnpf_pkg::COORD_W)'(mag_y) * (2*hnpf_pkg::COORD_W)'(mag_y);
   assign sq_z_in = (2*hnpf_pkg::COORD_W)'(mag_z) * (2*hnpf_pkg::COORD_W)'(mag_z);

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_sq_x_ff       <= sq_x_in;
         s2_sq_y_ff       <= sq_y_in;
         s2_sq_z_ff       <= sq_z_in;
         s2_keep_order_ff <= keep_order;
         s2_word_ff       <= s1_word_ff;
         s2_last_ff       <= s1_last_ff;
      end
   end

   // ---------------- stage 3: trim, count, result register ----------------
   logic [2*hnpf_pkg::COORD_W+1:0] rsq;
   logic                           beyond_cutoff;
   logic                           keep_final;
   logic [hnpf_pkg::COUNT_W-1:0]   running_kept_ff;
   logic [hnpf_pkg::COUNT_W-1:0]   running_kept_in;
   logic                           overflow_seen_ff;
   logic                           overflow_seen_in;
   logic [hnpf_pkg::COUNT_W-1:0]   count_now;
   logic                           overflow_now;

   // full 66-bit sum, never truncated before the compare
   assign rsq = (2*hnpf_pkg::COORD_W+2)'(s2_sq_x_ff)
              + (2*hnpf_pkg::COORD_W+2)'(s2_sq_y_ff)
              + (2*hnpf_pkg::COORD_W+2)'(s2_sq_z_ff);
   assign beyond_cutoff = rsq > {2'b00, cfg_ff.cutoff_sq};
   assign keep_final    = s2_keep_order_ff && !(cfg_ff.trim_mode && beyond_cutoff);

   always_comb begin
      count_now    = running_kept_ff;
      overflow_now = overflow_seen_ff;
      if (keep_final) begin
         if (running_kept_ff >= hnpf_pkg::COUNT_LIMIT) begin
            overflow_now = 1'b1;  // kept at the limit: count holds
         end else begin
            count_now = running_kept_ff + 1'b1;
         end
      end

      running_kept_in  = running_kept_ff;
      overflow_seen_in = overflow_seen_ff;
      if (out_load) begin
         // end of owner restarts the count for the next owner
         running_kept_in  = s2_last_ff ? '0 : count_now;
         overflow_seen_in = s2_last_ff ? 1'b0 : overflow_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_kept_ff  <= '0;
         overflow_seen_ff <= 1'b0;
      end else begin
         running_kept_ff  <= running_kept_in;
         overflow_seen_ff <= overflow_seen_in;
      end
   end

   logic                         rsp_keep_ff;
   logic [hnpf_pkg::WORD_W-1:0]  rsp_word_ff;
   logic [hnpf_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                         rsp_done_ff;
   logic                         rsp_overflow_ff;

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_keep_ff     <= keep_final;
         rsp_word_ff     <= s2_word_ff;
         rsp_count_ff    <= count_now;
         rsp_done_ff     <= s2_last_ff;
         rsp_overflow_ff <= overflow_now;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_keep       = rsp_keep_ff;
   assign rsp_kept_word  = rsp_word_ff;
   assign rsp_kept_count = rsp_count_ff;
   assign rsp_owner_done = rsp_done_ff;
   assign rsp_overflow   = rsp_overflow_ff;

   // ---------------- assertions ----------------
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      running_kept_ff <= hnpf_pkg::COUNT_LIMIT)
      else $error("per-owner count above its limit");

   a_overflow_at_limit: assert property (@(posedge clock) disable iff (reset)
      overflow_seen_ff |-> running_kept_ff == hnpf_pkg::COUNT_LIMIT)
      else $error("overflow flagged below the count limit");

   a_rsp_overflow_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> rsp_kept_count == hnpf_pkg::COUNT_LIMIT)
      else $error("result shows overflow without a saturated count");

   a_owner_restart: assert property (@(posedge clock) disable iff (reset)
      (out_load && s2_last_ff) |=> (running_kept_ff == '0 && !overflow_seen_ff))
      else $error("count not cleared after end of owner");

   a_full_stall_only: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request stalled while a stage could take it");

endmodule
